// ===== hdl/tod_pkg.sv =====
// Shared constants, opcodes and pipeline payload types for the time-of-day ALU.
package tod_pkg;

    localparam int FACTOR_WIDTH = 16;
    localparam int TIME_W       = 17;
    localparam int PROD_W       = TIME_W + FACTOR_WIDTH - 1;
    localparam int DIV_W        = (FACTOR_WIDTH > TIME_W) ? FACTOR_WIDTH : TIME_W;

    localparam int DAY_SECONDS   = 86400;
    localparam int LAST_SECOND   = 86399;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    // floor(x/3600) = (x*37283)>>27 and floor(x/60) = (x*2185)>>17 over the ranges used
    localparam int HOUR_RECIP = 37283;
    localparam int HOUR_SHIFT = 27;
    localparam int MIN_RECIP  = 2185;
    localparam int MIN_SHIFT  = 17;

    typedef enum logic [2:0] {
        OP_INC  = 3'd0,
        OP_DEC  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIVF = 3'd5,
        OP_DIVT = 3'd6,
        OP_PASS = 3'd7
    } op_t;

    typedef struct packed {
        logic [TIME_W-1:0] simple;
        logic              neg;
        op_t               op;
        logic              less;
        logic              equal;
        logic              err;
    } side_t;

    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [PROD_W-1:0] dvd;
        logic [PROD_W-1:0] quo;
        logic [DIV_W-1:0]  dvs;
        side_t             side;
    } div_t;

endpackage

// ===== hdl/time_of_day_modular_alu.sv =====
// Top level of the time-of-day modulo-86400 ALU.
// Pipeline: 2 front stages, one stage per product bit in the restoring divider,
// 5 back stages with the output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result is stalled.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module time_of_day_modular_alu (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        opcode,
    input  logic [tod_pkg::TIME_W-1:0]        time_a,
    input  logic [tod_pkg::TIME_W-1:0]        time_b,
    input  logic [tod_pkg::FACTOR_WIDTH-1:0]  factor,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tod_pkg::TIME_W-1:0]        result_time,
    output logic [4:0]                        hours,
    output logic [5:0]                        minutes,
    output logic [5:0]                        seconds,
    output logic [tod_pkg::TIME_W-1:0]        quotient,
    output logic                              a_less,
    output logic                              a_equal,
    output logic                              div_error
);
    import tod_pkg::*;

    logic  en;
    logic  f_vld, d_vld;
    div_t  f_dat, d_dat;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    tod_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (in_valid),
        .opcode  (opcode),
        .time_a  (time_a),
        .time_b  (time_b),
        .factor  (factor),
        .vld_out (f_vld),
        .dat_out (f_dat)
    );

    tod_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (f_vld),
        .dat_in  (f_dat),
        .vld_out (d_vld),
        .dat_out (d_dat)
    );

    tod_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .vld_in      (d_vld),
        .dat_in      (d_dat),
        .vld_out     (out_valid),
        .result_time (result_time),
        .hours       (hours),
        .minutes     (minutes),
        .seconds     (seconds),
        .quotient    (quotient),
        .a_less      (a_less),
        .a_equal     (a_equal),
        .div_error   (div_error)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_error |-> result_time == '0 && quotient == '0)
        else $error("division error without zero result");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_time < TIME_W'(DAY_SECONDS))
        else $error("result out of day range");

    a_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (22'(hours) * 22'(SECS_PER_HOUR) + 22'(minutes) * 22'(SECS_PER_MIN)
                       + 22'(seconds)) == 22'(result_time))
        else $error("time split does not match result");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(a_less && a_equal))
        else $error("less and equal both set");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_time) && $stable(quotient))
        else $error("stalled result changed");

endmodule

// ===== hdl/tod_front.sv =====
// Front end: operand reduction, factor magnitude, product, simple-op results, compare flags and divider operand select.
module tod_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               vld_in,
    input  logic [2:0]                         opcode,
    input  logic [tod_pkg::TIME_W-1:0]         time_a,
    input  logic [tod_pkg::TIME_W-1:0]         time_b,
    input  logic [tod_pkg::FACTOR_WIDTH-1:0]   factor,
    output logic                               vld_out,
    output tod_pkg::div_t                      dat_out
);
    import tod_pkg::*;

    localparam logic [TIME_W-1:0] DAY  = TIME_W'(DAY_SECONDS);
    localparam logic [TIME_W-1:0] LAST = TIME_W'(LAST_SECOND);

    logic                    v1_reg;
    op_t                     op1_reg;
    logic [TIME_W-1:0]       a1_reg, b1_reg;
    logic [FACTOR_WIDTH-1:0] fmag1_reg;
    logic                    fneg1_reg;

    logic [TIME_W-1:0]       a_next, b_next;
    logic [FACTOR_WIDTH-1:0] fmag_next;

    logic [TIME_W+FACTOR_WIDTH-1:0] prod;
    logic [TIME_W:0]                sum;
    logic [TIME_W-1:0]              simple;
    div_t                           d_next;
    div_t                           d_reg;
    logic                           v2_reg;

    always_comb
    begin
        a_next    = (time_a >= DAY) ? time_a - DAY : time_a;
        b_next    = (time_b >= DAY) ? time_b - DAY : time_b;
        fmag_next = factor[FACTOR_WIDTH-1] ? (~factor + 1'b1) : factor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg   <= op_t'(opcode);
            a1_reg    <= a_next;
            b1_reg    <= b_next;
            fmag1_reg <= fmag_next;
            fneg1_reg <= factor[FACTOR_WIDTH-1];
            d_reg     <= d_next;
        end
    end

    always_comb
    begin
        prod = {{FACTOR_WIDTH{1'b0}}, a1_reg} * {{TIME_W{1'b0}}, fmag1_reg};
        sum  = {1'b0, a1_reg} + {1'b0, b1_reg};
        case (op1_reg)
            OP_INC:  simple = (a1_reg == LAST) ? '0 : a1_reg + 1'b1;
            OP_DEC:  simple = (a1_reg == '0) ? LAST : a1_reg - 1'b1;
            OP_ADD:  simple = (sum >= {1'b0, DAY}) ? TIME_W'(sum - {1'b0, DAY})
                                                  : sum[TIME_W-1:0];
            OP_SUB:  simple = (a1_reg >= b1_reg) ? a1_reg - b1_reg
                                                 : TIME_W'(sum[TIME_W-1:0] + DAY
                                                   - b1_reg - b1_reg);
            OP_PASS: simple = a1_reg;
            default: simple = '0;
        endcase

        d_next             = '0;
        d_next.side.simple = simple;
        d_next.side.op     = op1_reg;
        d_next.side.less   = a1_reg < b1_reg;
        d_next.side.equal  = a1_reg == b1_reg;
        d_next.dvd         = PROD_W'(a1_reg);
        case (op1_reg)
            OP_MUL:
            begin
                d_next.dvd      = prod[PROD_W-1:0];
                d_next.dvs      = DIV_W'(DAY_SECONDS);
                d_next.side.neg = fneg1_reg;
            end
            OP_DIVF:
            begin
                d_next.dvs      = DIV_W'(fmag1_reg);
                d_next.side.neg = fneg1_reg;
                d_next.side.err = (fmag1_reg == '0);
            end
            OP_DIVT:
            begin
                d_next.dvs      = DIV_W'(b1_reg);
                d_next.side.err = (b1_reg == '0);
            end
            default:
            begin
                d_next.dvs = DIV_W'(DAY_SECONDS);
            end
        endcase
    end

    assign vld_out = v2_reg;
    assign dat_out = d_reg;

endmodule

// ===== hdl/tod_divider.sv =====
// Restoring divider pipeline: one quotient bit per register stage.
module tod_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vld_in,
    input  tod_pkg::div_t  dat_in,
    output logic           vld_out,
    output tod_pkg::div_t  dat_out
);
    import tod_pkg::*;

    function automatic div_t div_step(div_t d);
        logic [DIV_W:0] trial;
        logic           ge;
        div_t           r;
        trial = {d.rem, d.dvd[PROD_W-1]};
        ge    = trial >= {1'b0, d.dvs};
        r     = d;
        r.rem = ge ? DIV_W'(trial - {1'b0, d.dvs}) : trial[DIV_W-1:0];
        r.dvd = {d.dvd[PROD_W-2:0], 1'b0};
        r.quo = {d.quo[PROD_W-2:0], ge};
        return r;
    endfunction

    logic [PROD_W-1:0] v_reg;
    div_t              d_reg [PROD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PROD_W-2:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= div_step(dat_in);
            for (int i = 1; i < PROD_W; i++)
            begin
                d_reg[i] <= div_step(d_reg[i-1]);
            end
        end
    end

    assign vld_out = v_reg[PROD_W-1];
    assign dat_out = d_reg[PROD_W-1];

endmodule

// ===== hdl/tod_back.sv =====
// Back end: result select, sign fix-up and hours/minutes/seconds split.
module tod_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        vld_in,
    input  tod_pkg::div_t               dat_in,
    output logic                        vld_out,
    output logic [tod_pkg::TIME_W-1:0]  result_time,
    output logic [4:0]                  hours,
    output logic [5:0]                  minutes,
    output logic [5:0]                  seconds,
    output logic [tod_pkg::TIME_W-1:0]  quotient,
    output logic                        a_less,
    output logic                        a_equal,
    output logic                        div_error
);
    import tod_pkg::*;

    localparam logic [TIME_W-1:0] DAY = TIME_W'(DAY_SECONDS);

    typedef struct packed {
        logic [TIME_W-1:0] res;
        logic [TIME_W-1:0] quo;
        logic              less;
        logic              equal;
        logic              err;
    } res_t;

    logic [4:0] v_reg;
    res_t       r1_reg, r2_reg, r3_reg, r4_reg, r5_reg;
    logic [4:0] h2_reg, h3_reg, h4_reg, h5_reg;
    logic [11:0] rm3_reg, rm4_reg;
    logic [5:0] m5_reg, s5_reg;

    res_t                r1_next;
    logic [TIME_W-1:0]   rmd, q;
    logic [TIME_W+15:0]  hprod;
    logic [22:0]         mprod;

    always_comb
    begin
        rmd = TIME_W'(dat_in.rem);
        q   = dat_in.quo[TIME_W-1:0];
        r1_next       = '0;
        r1_next.less  = dat_in.side.less;
        r1_next.equal = dat_in.side.equal;
        r1_next.err   = dat_in.side.err;
        case (dat_in.side.op)
            OP_MUL:  r1_next.res = (dat_in.side.neg && rmd != '0) ? DAY - rmd : rmd;
            OP_DIVF: r1_next.res = (dat_in.side.neg && q != '0) ? DAY - q : q;
            OP_DIVT: r1_next.quo = q;
            default: r1_next.res = dat_in.side.simple;
        endcase
        if (dat_in.side.err)
        begin
            r1_next.res = '0;
            r1_next.quo = '0;
        end
        hprod = {16'b0, r1_reg.res} * (TIME_W+16)'(HOUR_RECIP);
        mprod = {11'b0, rm4_reg} * 23'(MIN_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], vld_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg  <= r1_next;
            r2_reg  <= r1_reg;
            h2_reg  <= hprod[HOUR_SHIFT+4:HOUR_SHIFT];
            r3_reg  <= r2_reg;
            h3_reg  <= h2_reg;
            r4_reg  <= r3_reg;
            h4_reg  <= h3_reg;
            rm3_reg <= 12'(r2_reg.res - {{(TIME_W-5){1'b0}}, h2_reg}
                           * TIME_W'(SECS_PER_HOUR));
            rm4_reg <= rm3_reg;
            r5_reg  <= r4_reg;
            h5_reg  <= h4_reg;
            m5_reg  <= mprod[MIN_SHIFT+5:MIN_SHIFT];
            s5_reg  <= 6'(rm4_reg - {6'b0, mprod[MIN_SHIFT+5:MIN_SHIFT]}
                          * 12'(SECS_PER_MIN));
        end
    end

    assign vld_out     = v_reg[4];
    assign result_time = r5_reg.res;
    assign hours       = h5_reg;
    assign minutes     = m5_reg;
    assign seconds     = s5_reg;
    assign quotient    = r5_reg.quo;
    assign a_less      = r5_reg.less;
    assign a_equal     = r5_reg.equal;
    assign div_error   = r5_reg.err;

endmodule
